// ----- hw/rtl/mtecho_pkg.sv -----
// Shared constants, register indexes and saturation helper for the multi-tap echo core.
package mtecho_pkg;

  // Default sizes
  localparam int unsigned MAX_TAPS_DEF   = 16;
  localparam int unsigned HIST_DEPTH_DEF = 65536;

  // Sample limits, symmetric
  localparam int SAMPLE_LIMIT = 32767;

  // Field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned TIDX_W    = 4;
  localparam int unsigned TCOUNT_W  = 5;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned ACC_W     = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_COEFF = 1'd1;

  // Operation codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_TAP_WRITE = 1'b1;

  // Clamp a wide signed value to +-SAMPLE_LIMIT
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [33:0] v);
    logic signed [33:0] lim_hi;
    logic signed [33:0] lim_lo;
    lim_hi = 34'(SAMPLE_LIMIT);
    lim_lo = -34'(SAMPLE_LIMIT);
    if (v > lim_hi) begin
      return lim_hi[SAMPLE_W-1:0];
    end else if (v < lim_lo) begin
      return lim_lo[SAMPLE_W-1:0];
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/multi_tap_echo_with_damping_core.sv -----
// Multi-tap feedback echo with one-pole damping: sequencer, tap table, history and shared MAC.
//
// Sample items (opcode 0) run through up to MAX_TAPS echo taps in order, each adding
// gain * history[n - delay] (Q1.14, floored, saturated to +-32767), then a one-pole
// lowpass weighted by damp_coeff; the saturated result is returned and written back into
// the history, so the echo feeds back. Tap-write items (opcode 1) give no result. The
// taps in use are tap_count capped at MAX_TAPS. The sequencer turns idle, ready for the
// next item, in the same cycle as out_valid rises. Each tap steps through the tap-table
// read, the history-memory read, the single shared 32x18 multiplier and the accumulate/
// saturate, and the lowpass uses that same multiplier twice before the final sum.
// Input is accepted only while the sequencer is idle; the result waits in an output
// register, so a pending result does not block tap writes, and a following sample holds
// in its final step until that register is free. HIST_DEPTH must be a power of two; the
// history needs no clearing pass after reset, since a fill pointer marks slots not yet
// written, which read as zero.
module multi_tap_echo_with_damping_core
  import mtecho_pkg::*;
#(
  parameter int unsigned MAX_TAPS   = MAX_TAPS_DEF,
  parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [TIDX_W-1:0]           tap_index,
  input  logic [DELAY_W-1:0]          tap_delay,
  input  logic signed [GAIN_W-1:0]    tap_gain,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample
);

  localparam int unsigned AW     = $clog2(HIST_DEPTH);
  localparam int unsigned DLW    = (AW > DELAY_W) ? AW : DELAY_W;
  localparam int unsigned TAW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned IXW    = (TAW > TIDX_W) ? TAW : TIDX_W;
  localparam int unsigned CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int unsigned CMP_W  = (CNT_W > TCOUNT_W) ? CNT_W : TCOUNT_W;
  localparam int unsigned MA_W   = 32;
  localparam int unsigned MB_W   = 18;
  localparam int unsigned MP_W   = MA_W + MB_W;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_TAP_RD    = 8'b0000_0010,
    S_HIST_RD   = 8'b0000_0100,
    S_TAP_MUL   = 8'b0000_1000,
    S_TAP_ACC   = 8'b0001_0000,
    S_DAMP_MUL1 = 8'b0010_0000,
    S_DAMP_MUL2 = 8'b0100_0000,
    S_DAMP_SUM  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // config registers
  logic [TCOUNT_W-1:0] tap_count;
  logic [COEFF_W-1:0]  damp_coeff;

  // sequencer / datapath registers
  logic [CMP_W-1:0]          n_taps;
  logic [CMP_W-1:0]          tap_i;
  logic signed [SAMPLE_W-1:0] y;
  logic signed [ACC_W-1:0]   damp_acc;
  logic signed [33:0]        damp_part;
  logic signed [MP_W-1:0]    prod;
  logic [AW-1:0]             wp;
  logic                      full;

  // tap table
  logic [DELAY_W-1:0]        tap_delay_mem [MAX_TAPS];
  logic signed [GAIN_W-1:0]  tap_gain_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]       tap_vld;
  logic [DELAY_W-1:0]        tap_delay_q;
  logic signed [GAIN_W-1:0]  tap_gain_q;
  logic                      tap_vld_q;

  // history memory
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic                       hist_ok_q;

  // combinational helpers
  logic                      in_xfer;
  logic                      tap_wr;
  logic [IXW-1:0]            tap_wr_idx;
  logic [TAW-1:0]            tap_rd_idx;
  logic [DLW-1:0]            dly_ext;
  logic [AW-1:0]             raddr;
  logic                      raddr_ok;
  logic [CMP_W-1:0]          cnt_cap;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [33:0]        tap_sum;
  logic signed [33:0]        acc_sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [SAMPLE_W-1:0] res;
  logic                      commit;
  logic [COEFF_W:0]          one_minus_d;

  assign in_ready   = (state == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign tap_wr_idx = IXW'(tap_index);
  assign tap_wr     = in_xfer && (opcode == OP_TAP_WRITE) && (32'(tap_index) < MAX_TAPS);
  assign tap_rd_idx = tap_i[TAW-1:0];
  assign cnt_cap    = (CMP_W'(tap_count) > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS)
                                                               : CMP_W'(tap_count);

  // history read address: write pointer minus delay, modulo depth
  assign dly_ext  = DLW'(tap_delay_q);
  assign raddr    = wp - dly_ext[AW-1:0];
  assign raddr_ok = full || (raddr < wp);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= '0;
      damp_coeff <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT:  tap_count  <= cfg_data[TCOUNT_W-1:0];
        REG_DAMP_COEFF: damp_coeff <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // tap table: write on tap-write transfer, registered read at current tap
  always_ff @(posedge clk) begin
    if (tap_wr) begin
      tap_delay_mem[tap_wr_idx[TAW-1:0]] <= tap_delay;
      tap_gain_mem[tap_wr_idx[TAW-1:0]]  <= tap_gain;
    end
    tap_delay_q <= tap_delay_mem[tap_rd_idx];
    tap_gain_q  <= tap_gain_mem[tap_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_vld   <= '0;
      tap_vld_q <= 1'b0;
    end else begin
      if (tap_wr) begin
        tap_vld[tap_wr_idx[TAW-1:0]] <= 1'b1;
      end
      tap_vld_q <= tap_vld[tap_rd_idx];
    end
  end

  // history memory: write final output, registered read
  always_ff @(posedge clk) begin
    if (commit) begin
      hist_mem[wp] <= res;
    end
    hist_q <= hist_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_ok_q <= 1'b0;
    end else begin
      hist_ok_q <= raddr_ok;
    end
  end

  // shared multiplier operand select; unwritten taps give a zero product
  assign one_minus_d = (COEFF_W+1)'(1 << COEFF_W) - (COEFF_W+1)'(damp_coeff);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TAP_MUL: begin
        mul_a = tap_vld_q ? MA_W'(tap_gain_q) : '0;
        mul_b = (tap_vld_q && hist_ok_q) ? MB_W'(hist_q) : '0;
      end
      S_DAMP_MUL1: begin
        mul_a = damp_acc;
        mul_b = MB_W'(signed'({1'b0, damp_coeff}));
      end
      S_DAMP_MUL2: begin
        mul_a = MA_W'(y);
        mul_b = MB_W'(signed'({1'b0, one_minus_d}));
      end
      default: ;
    endcase
  end

  // tap accumulate and lowpass sum
  assign tap_sum  = 34'(y) + 34'(prod >>> 14);
  assign acc_sum  = damp_part + 34'(prod);
  assign acc_next = acc_sum[ACC_W-1:0];
  assign res      = sat_sample(34'(acc_next >>> 16));
  assign commit   = (state == S_DAMP_SUM) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && (opcode == OP_SAMPLE)) begin
          state_next = (cnt_cap == '0) ? S_DAMP_MUL1 : S_TAP_RD;
        end
      end
      S_TAP_RD:    state_next = S_HIST_RD;
      S_HIST_RD:   state_next = S_TAP_MUL;
      S_TAP_MUL:   state_next = S_TAP_ACC;
      S_TAP_ACC:   state_next = (tap_i + 1'b1 == n_taps) ? S_DAMP_MUL1 : S_TAP_RD;
      S_DAMP_MUL1: state_next = S_DAMP_MUL2;
      S_DAMP_MUL2: state_next = S_DAMP_SUM;
      S_DAMP_SUM:  state_next = commit ? S_IDLE : S_DAMP_SUM;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      damp_acc <= '0;
      wp       <= '0;
      full     <= 1'b0;
      tap_i    <= '0;
      n_taps   <= '0;
    end else begin
      state <= state_next;
      if (in_xfer && (opcode == OP_SAMPLE)) begin
        tap_i  <= '0;
        n_taps <= cnt_cap;
      end
      if (state == S_TAP_ACC) begin
        tap_i <= tap_i + 1'b1;
      end
      if (commit) begin
        damp_acc <= acc_next;
        wp       <= wp + 1'b1;
        if (wp == AW'(HIST_DEPTH - 1)) begin
          full <= 1'b1;
        end
      end
    end
  end

  // datapath payload registers; the product holds while the final sum waits
  always_ff @(posedge clk) begin
    if (state != S_DAMP_SUM) begin
      prod <= mul_a * mul_b;
    end
    if (in_xfer && (opcode == OP_SAMPLE)) begin
      y <= sat_sample(34'(in_sample));
    end else if (state == S_TAP_ACC) begin
      y <= sat_sample(tap_sum);
    end
    if (state == S_DAMP_MUL2) begin
      damp_part <= 34'(prod >>> 16);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_sample <= res;
    end
  end

`ifndef ASSERT_OFF
  // sequencer stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  // a sample transfer always starts the tap/damp sequence
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (opcode == OP_SAMPLE)) |=> (state != S_IDLE))
    else $error("sample transfer did not start processing");

  // each committed result advances the history pointer by one
  a_wp_advance: assert property (@(posedge clk) disable iff (rst)
    commit |=> (wp == $past(wp) + 1'b1) && out_valid)
    else $error("history pointer or output not updated on commit");

  // history fill flag never drops once set
  a_full_sticky: assert property (@(posedge clk) disable iff (rst) full |=> full)
    else $error("history fill flag cleared");

  // output is always within the symmetric limit
  a_out_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_sample != 16'sh8000))
    else $error("output outside saturation limit");
`endif

endmodule

// ----- verif/tb_multi_tap_echo_with_damping_core.sv -----
// Self-checking testbench for the multi-tap feedback echo core with damping.
`timescale 1ns / 100ps

module tb_multi_tap_echo_with_damping_core;
  import mtecho_pkg::*;

  localparam int unsigned HIST_AW   = $clog2(HIST_DEPTH_DEF);
  localparam int unsigned HOLD_LEN  = 700;   // long receiver hold-off, cycles
  localparam int unsigned SETTLE    = 100;   // exceeds the worst-case sample latency
  localparam int unsigned PHASE_LEN = 130;

  // Echo predictor plus the queue of output samples still owed by the core
  class echo_tracker;
    bit signed [SAMPLE_W-1:0] hist [HIST_DEPTH_DEF];
    bit [HIST_AW-1:0]         wptr;
    bit [DELAY_W-1:0]         delays [MAX_TAPS_DEF];
    bit signed [GAIN_W-1:0]   gains [MAX_TAPS_DEF];
    longint                   damp_acc;
    bit [TCOUNT_W-1:0]        tap_count;
    bit [COEFF_W-1:0]         damp_coeff;
    bit signed [SAMPLE_W-1:0] pending_samples [$];
    int unsigned              fails;
    int unsigned              results_checked;

    function longint limit(longint v);
      if (v > SAMPLE_LIMIT) return SAMPLE_LIMIT;
      if (v < -SAMPLE_LIMIT) return -SAMPLE_LIMIT;
      return v;
    endfunction

    // Apply one accepted item; samples queue their expected output
    function void take_item(bit op, bit [TIDX_W-1:0] idx, bit [DELAY_W-1:0] dly,
                            bit signed [GAIN_W-1:0] gn, bit signed [SAMPLE_W-1:0] smp);
      longint y;
      longint prod;
      longint acc;
      int unsigned n;
      bit [HIST_AW-1:0] addr;
      if (op == OP_TAP_WRITE) begin
        if (idx < MAX_TAPS_DEF) begin
          delays[idx] = dly;
          gains[idx]  = gn;
        end
        return;
      end
      y = limit(longint'(smp));
      n = (tap_count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_count;
      for (int i = 0; i < n; i++) begin
        addr = wptr - HIST_AW'(delays[i]);   // wraps modulo history depth
        prod = longint'(gains[i]) * longint'(hist[addr]);
        y = limit(y + (prod >>> 14));
      end
      // one-pole lowpass, Q15.16 state
      acc = damp_acc * longint'(damp_coeff) + y * 65536 * (65536 - longint'(damp_coeff));
      damp_acc = acc >>> 16;
      y = limit(damp_acc >>> 16);
      hist[wptr] = y[SAMPLE_W-1:0];
      wptr++;
      pending_samples.push_back(y[SAMPLE_W-1:0]);
    endfunction

    function void match_output(logic signed [SAMPLE_W-1:0] got);
      bit signed [SAMPLE_W-1:0] want;
      if (pending_samples.size() == 0) begin
        fails++;
        $display("%0t: out_sample %0d with no sample outstanding", $time, got);
        return;
      end
      want = pending_samples.pop_front();
      results_checked++;
      if (got !== want) begin
        fails++;
        $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DAT_W-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       opcode;
  logic [TIDX_W-1:0]          tap_index;
  logic [DELAY_W-1:0]         tap_delay;
  logic signed [GAIN_W-1:0]   tap_gain;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  echo_tracker tracker = new();
  int unsigned burst_left;
  int unsigned rx_hold;
  int unsigned rx_span;
  int unsigned rx_mode;
  int unsigned rx_tick;

  multi_tap_echo_with_damping_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .tap_index  (tap_index),
    .tap_delay  (tap_delay),
    .tap_gain   (tap_gain),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: stall patterns, occasional long hold-off, check each transfer
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
      rx_span = 0;
      rx_tick = 0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.match_output(out_sample);
        if (tracker.results_checked % 300 == 150) rx_hold = HOLD_LEN;
      end
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(20, 120);
      end
      rx_span--;
      rx_tick++;
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (rx_tick % 3 == 0);
        endcase
      end
    end
  end

  // One input transfer, with bursts and random gaps in front
  task automatic send_item(input logic op, input logic [TIDX_W-1:0] idx,
                           input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] gn,
                           input logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    opcode    <= op;
    tap_index <= idx;
    tap_delay <= dly;
    tap_gain  <= gn;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(op, idx, dly, gn, smp);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    send_item(OP_SAMPLE, '0, '0, '0, smp);
  endtask

  task automatic send_tap(input logic [TIDX_W-1:0] idx, input logic [DELAY_W-1:0] dly,
                          input logic [GAIN_W-1:0] gn);
    send_item(OP_TAP_WRITE, idx, dly, gn, '0);
  endtask

  // Wait for every owed sample, then let the sequencer go idle
  task automatic settle_core();
    in_valid <= 1'b0;
    while (tracker.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_regs(input int unsigned cnt, input int unsigned coeff);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= CFG_DAT_W'(cnt);
    @(posedge clk);
    cfg_index <= REG_DAMP_COEFF;
    cfg_data  <= CFG_DAT_W'(coeff);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.tap_count  = TCOUNT_W'(cnt);
    tracker.damp_coeff = COEFF_W'(coeff);
  endtask

  // Random item: mostly samples, some tap rewrites with mostly short delays
  task automatic send_random_item();
    int unsigned pick;
    logic [DELAY_W-1:0]  dly;
    logic [GAIN_W-1:0]   gn;
    logic [SAMPLE_W-1:0] smp;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    dly = DELAY_W'($urandom_range(0, 1024));
      2:       dly = DELAY_W'($urandom);
      default: dly = DELAY_W'($urandom_range(1, 64));
    endcase
    gn  = $urandom_range(0, 1) ? GAIN_W'($urandom)
                               : GAIN_W'(int'($urandom_range(0, 16383)) - 8192);
    case ($urandom_range(0, 9))
      0:       smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2, 3: smp = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
      default: smp = SAMPLE_W'($urandom);
    endcase
    send_item((pick < 15) ? OP_TAP_WRITE : OP_SAMPLE, TIDX_W'($urandom), dly, gn, smp);
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = OP_SAMPLE;
    tap_index  = '0;
    tap_delay  = '0;
    tap_gain   = '0;
    in_sample  = '0;
    out_ready  = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no taps, no damping: output follows the limited input
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    settle_core();

    // all taps, extreme gains and delays (zero delay reads the oldest slot)
    set_regs(MAX_TAPS_DEF, 0);
    send_tap(4'd0, 16'd1, 16'h7fff);
    send_tap(4'd1, 16'd0, 16'h8000);
    send_tap(4'd2, 16'hffff, 16'sd16384);
    send_tap(4'd15, 16'd2, -16'sd16384);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd20000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
    settle_core();

    // tap count beyond the table, heaviest damping
    set_regs(31, 16'hffff);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1000);
    send_sample(16'sd0);
    settle_core();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(MAX_TAPS_DEF, 0);
        1: set_regs(31, 16'hffff);
        2: set_regs(0, 40000);
        3: set_regs(1, 32768);
        default: set_regs($urandom_range(0, 31), $urandom_range(0, 65535));
      endcase
      repeat (PHASE_LEN) send_random_item();
      settle_core();
    end

    if (tracker.fails == 0 && tracker.pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mtecho_pkg.sv
hw/rtl/multi_tap_echo_with_damping_core.sv
verif/tb_multi_tap_echo_with_damping_core.sv
